// ===== design/prq_pkg.sv =====
// Shared types and constants for the priority ready queue.
package prq_pkg;

   localparam int NUM_PROCS   = 16;
   localparam int QUEUE_DEPTH = 16;
   localparam int PRIO_BITS   = 8;

   localparam int PROC_W = $clog2(NUM_PROCS);
   localparam int QIDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

   typedef logic [PRIO_BITS-1:0] prio_type;
   typedef logic [3:0]           id_type;
   typedef logic [CNT_W-1:0]     count_type;

   typedef enum logic [2:0] {
      REQ_SET    = 3'd0,
      REQ_CLEAR  = 3'd1,
      REQ_ENQ    = 3'd2,
      REQ_DEQ    = 3'd3,
      REQ_REMOVE = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_FULL     = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_NOENTRY  = 3'd4
   } status_type;

   // broadcast control for the queue cells
   typedef struct packed {
      logic insert;
      logic shift_all;
      logic remove;
   } cell_ctl_type;

   // process table write port
   typedef struct packed {
      logic              set;
      logic              clr;
      logic [PROC_W-1:0] idx;
      prio_type          prio;
   } tbl_wr_type;

endpackage

// ===== design/prq_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface prq_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [3:0] proc_id;
   logic [7:0] prio_in;

   modport source (output valid, req_type, proc_id, prio_in, input ready);
   modport sink   (input valid, req_type, proc_id, prio_in, output ready);
endinterface

interface prq_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] out_id;
   logic [7:0] out_prio;
   logic [2:0] status;
   logic [4:0] queue_count;

   modport source (output valid, out_id, out_prio, status, queue_count, input ready);
   modport sink   (input valid, out_id, out_prio, status, queue_count, output ready);
endinterface

// ===== design/prq_cell.sv =====
// One queue cell: holds an entry, compares it and shifts with its neighbors.
module prq_cell (
   input  logic                 clock,
   input  prq_pkg::cell_ctl_type ctl,
   input  logic                 occ,
   input  prq_pkg::id_type      key_id,
   input  prq_pkg::prio_type    new_prio,
   input  logic                 left_le,
   input  logic                 left_seen,
   input  prq_pkg::id_type      left_id,
   input  prq_pkg::prio_type    left_prio,
   input  prq_pkg::id_type      right_id,
   input  prq_pkg::prio_type    right_prio,
   output logic                 le,
   output logic                 seen,
   output prq_pkg::id_type      id,
   output prq_pkg::prio_type    prio
);
   import prq_pkg::*;

   id_type   id_ff, id_in;
   prio_type prio_ff, prio_in;
   logic     match;

   assign le    = occ && (prio_ff <= new_prio);
   assign match = occ && (id_ff == key_id);
   assign seen  = left_seen | match;
   assign id    = id_ff;
   assign prio  = prio_ff;

   always_comb begin
      id_in   = id_ff;
      prio_in = prio_ff;
      if (ctl.shift_all || (ctl.remove && seen)) begin
         id_in   = right_id;
         prio_in = right_prio;
      end else if (ctl.insert && !le) begin
         if (left_le) begin
            id_in   = key_id;
            prio_in = new_prio;
         end else begin
            id_in   = left_id;
            prio_in = left_prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

endmodule

// ===== design/prq_table.sv =====
// Process table: priority and valid mark per process ID.
module prq_table (
   input  logic                      clock,
   input  logic                      reset,
   input  prq_pkg::tbl_wr_type       wr,
   input  logic [prq_pkg::PROC_W-1:0] rd_idx,
   output prq_pkg::prio_type         rd_prio,
   output logic                      rd_valid
);
   import prq_pkg::*;

   prio_type              prio_ff [NUM_PROCS];
   logic [NUM_PROCS-1:0]  valid_ff, valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr.set) begin
         valid_in[wr.idx] = 1'b1;
      end else if (wr.clr) begin
         valid_in[wr.idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.set) begin
         prio_ff[wr.idx] <= wr.prio;
      end
   end

   assign rd_valid = valid_ff[rd_idx];
   assign rd_prio  = rd_valid ? prio_ff[rd_idx] : '0;

endmodule

// ===== design/priority_ready_queue_core.sv =====
// Priority ready queue with process table, built as a chain of sorted cells.
//
// Requests arrive on req_port (valid/ready): set or clear a table entry,
// enqueue an ID at its table priority, dequeue the head, or remove the
// first queued entry with a given ID. Each request yields exactly one
// response on rsp_port with the dequeued ID and priority, a status code
// and the queue fill count after the request.
// Every cell compares its entry against the request in parallel and takes
// its own, the new, its left or its right neighbor's entry, so any request
// finishes in the accept cycle. The response sits in an output register
// and shows in the cycle after acceptance. With responses taken, one
// request per cycle is sustained; the one output register sets that figure.
// While the response is not taken, req_port.ready stays low, except in
// the cycle the response is taken, where a new request is accepted.
// Reset empties the queue and clears all table valid marks; no clearing
// pass is needed.
module priority_ready_queue_core (
   input logic      clock,
   input logic      reset,
   prq_req_if.sink   req_port,
   prq_rsp_if.source rsp_port
);
   import prq_pkg::*;

   count_type    count_ff, count_in;
   logic         rsp_valid_ff, rsp_valid_in;
   id_type       out_id_ff, out_id_in;
   prio_type     out_prio_ff, out_prio_in;
   status_type   status_ff, status_in;

   logic         fire;
   logic         in_table;
   logic         full;
   logic         empty;
   logic         found;
   tbl_wr_type   tbl_wr;
   prio_type     tbl_prio;
   logic         tbl_valid;
   cell_ctl_type ctl;
   prio_type     req_prio;

   logic     cell_le   [QUEUE_DEPTH];
   logic     cell_seen [QUEUE_DEPTH];
   id_type   cell_id   [QUEUE_DEPTH];
   prio_type cell_prio [QUEUE_DEPTH];

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign fire           = req_port.valid && req_port.ready;
   assign in_table       = 32'(req_port.proc_id) < NUM_PROCS;
   assign full           = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty          = count_ff == '0;
   assign found          = cell_seen[QUEUE_DEPTH-1];
   assign req_prio       = PRIO_BITS'(req_port.prio_in);

   prq_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .rd_idx   (PROC_W'(req_port.proc_id)),
      .rd_prio  (tbl_prio),
      .rd_valid (tbl_valid)
   );

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic     l_le;
      logic     l_seen;
      id_type   l_id;
      prio_type l_prio;
      id_type   r_id;
      prio_type r_prio;

      if (i == 0) begin : g_head
         assign l_le   = 1'b1;
         assign l_seen = 1'b0;
         assign l_id   = req_port.proc_id;
         assign l_prio = tbl_prio;
      end else begin : g_body
         assign l_le   = cell_le[i-1];
         assign l_seen = cell_seen[i-1];
         assign l_id   = cell_id[i-1];
         assign l_prio = cell_prio[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign r_id   = cell_id[i];
         assign r_prio = cell_prio[i];
      end else begin : g_mid
         assign r_id   = cell_id[i+1];
         assign r_prio = cell_prio[i+1];
      end

      prq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occ        (CNT_W'(i) < count_ff),
         .key_id     (req_port.proc_id),
         .new_prio   (tbl_prio),
         .left_le    (l_le),
         .left_seen  (l_seen),
         .left_id    (l_id),
         .left_prio  (l_prio),
         .right_id   (r_id),
         .right_prio (r_prio),
         .le         (cell_le[i]),
         .seen       (cell_seen[i]),
         .id         (cell_id[i]),
         .prio       (cell_prio[i])
      );
   end

   always_comb begin
      ctl         = '0;
      tbl_wr.set  = 1'b0;
      tbl_wr.clr  = 1'b0;
      tbl_wr.idx  = PROC_W'(req_port.proc_id);
      tbl_wr.prio = req_prio;
      status_in   = ST_OK;
      out_id_in   = '0;
      out_prio_in = '0;
      case (req_code_type'(req_port.req_type))
         REQ_SET: begin
            if (in_table) begin
               tbl_wr.set = fire;
            end else begin
               status_in = ST_NOENTRY;
            end
         end
         REQ_CLEAR: begin
            if (in_table) begin
               tbl_wr.clr = fire;
            end else begin
               status_in = ST_NOENTRY;
            end
         end
         REQ_ENQ: begin
            if (!in_table || !tbl_valid) begin
               status_in = ST_NOENTRY;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               ctl.insert = fire;
            end
         end
         REQ_DEQ: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               ctl.shift_all = fire;
               out_id_in     = cell_id[0];
               out_prio_in   = cell_prio[0];
            end
         end
         REQ_REMOVE: begin
            if (found) begin
               ctl.remove = fire;
            end else begin
               status_in = ST_NOTFOUND;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.insert) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.shift_all || ctl.remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   logic [4:0] rsp_count_ff;

   always_ff @(posedge clock) begin
      if (fire) begin
         out_id_ff    <= out_id_in;
         out_prio_ff  <= out_prio_in;
         status_ff    <= status_in;
         rsp_count_ff <= 5'(count_in);
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.out_id      = out_id_ff;
   assign rsp_port.out_prio    = 8'(out_prio_ff);
   assign rsp_port.status      = status_ff;
   assign rsp_port.queue_count = rsp_count_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_fire_rsp : assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("accepted item gave no response");

   a_deq_count : assert property (@(posedge clock) disable iff (reset)
      ctl.shift_all |=> count_ff == $past(count_ff) - 1'b1)
      else $error("dequeue did not drop the count");

   a_sorted : assert property (@(posedge clock) disable iff (reset)
      count_ff >= CNT_W'(2) |-> cell_prio[0] <= cell_prio[1])
      else $error("queue head out of order");

endmodule
